@@ rtl/ehd_pkg.sv @@
// shared types, field widths and codes for the hall call dispatcher
package ehd_pkg;

	// field widths fixed by the stream beat layout
	localparam int FLOOR_W = 6;
	localparam int STOP_W  = 6;
	localparam int SLOT_W  = 3;
	localparam int CNT_W   = 4;
	localparam int STRAT_W = 2;
	localparam int CAR_W   = 3;

	// default table depth
	localparam int DEF_MAX_CARS = 8;

	// worst score: doubled distance plus five times the stop count
	localparam int FLOOR_MAX = (1 << FLOOR_W) - 1;
	localparam int STOP_MAX  = (1 << STOP_W) - 1;
	localparam int KEY_W     = $clog2(2 * FLOOR_MAX + 5 * STOP_MAX + 1);

	// register indexes
	localparam logic REG_STRATEGY = 1'b0;
	localparam logic REG_CARS     = 1'b1;

	// dispatch rules
	localparam logic [STRAT_W-1:0] STRAT_NEAREST = 2'd0;
	localparam logic [STRAT_W-1:0] STRAT_LEAST   = 2'd1;
	localparam logic [STRAT_W-1:0] STRAT_SCORE   = 2'd2;

	// beat kinds
	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_CALL   = 1'b1;

	// hall call directions
	localparam logic DIR_UP   = 1'b0;
	localparam logic DIR_DOWN = 1'b1;

	typedef enum logic [1:0] {
		MOT_IDLE  = 2'd0,
		MOT_UP    = 2'd1,
		MOT_DOWN  = 2'd2,
		MOT_OTHER = 2'd3
	} motion_t;

	// one car table entry
	typedef struct packed {
		logic [STOP_W-1:0]  stops;
		logic               fault;
		motion_t            motion;
		logic [FLOOR_W-1:0] floor;
	} car_entry_t;

	localparam int ENTRY_W = $bits(car_entry_t);

	// per-car verdict handed from the evaluator to the scan control
	typedef struct packed {
		logic               pref_ok;
		logic [KEY_W-1:0]   pref_key;
		logic               alt_ok;
		logic [FLOOR_W-1:0] alt_key;
	} eval_t;

endpackage

@@ rtl/elevator_hall_call_dispatcher.sv @@
// Hall call dispatcher: a status update gives no result beat.
// A hall call goes from accept through the scan, drain and finish states to the result beat;
// the car table ram read port scans one entry per cycle, and with no car scanned both are skipped.
// One item is worked at a time; a new item is taken while the result beat waits.
// arst_n clears control state and both registers; the car table is not cleared.
module elevator_hall_call_dispatcher import ehd_pkg::*; #(
	parameter int MAX_CARS = DEF_MAX_CARS
) (
	input  logic               clk,
	input  logic               arst_n,
	// input stream
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// slot[2:0], car_floor[8:3], motion[10:9], safety_fault[11],
	// pending_stops[17:12], call_floor[23:18], call_direction[24]
	input  logic [31:0]        s_axis_tdata,
	// mode[0]
	input  logic               s_axis_tuser,
	// result stream
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// chosen_car[2:0]
	output logic [7:0]         m_axis_tdata,
	// found[0]
	output logic               m_axis_tuser,
	// configuration writes
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [CNT_W-1:0]   cfg_wdata
);

	localparam int IDX_W = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;

	// beat field offsets
	localparam int OFS_FLOOR = SLOT_W;
	localparam int OFS_MOT   = OFS_FLOOR + FLOOR_W;
	localparam int OFS_FAULT = OFS_MOT + 2;
	localparam int OFS_STOPS = OFS_FAULT + 1;
	localparam int OFS_CALL  = OFS_STOPS + STOP_W;
	localparam int OFS_DIR   = OFS_CALL + FLOOR_W;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t             state_q;
	logic [STRAT_W-1:0] strategy_q;
	logic [CNT_W-1:0]   cars_q;

	logic [FLOOR_W-1:0] call_floor_q;
	logic               call_dir_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   rd_cnt_q;

	logic               eval_vld_s1;
	logic [CNT_W-1:0]   eval_idx_s1;

	logic               pref_found_q;
	logic [KEY_W-1:0]   pref_key_q;
	logic [CNT_W-1:0]   pref_idx_q;
	logic               alt_found_q;
	logic [FLOOR_W-1:0] alt_key_q;
	logic [CNT_W-1:0]   alt_idx_q;

	logic               out_vld_q;
	logic               out_found_q;
	logic [CAR_W-1:0]   out_idx_q;

	logic               acc;
	logic               upd_acc;
	logic               call_acc;
	logic [SLOT_W-1:0]  in_slot;
	car_entry_t         in_entry;
	logic [CNT_W-1:0]   n_sat;
	logic               ram_we;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	eval_t              verdict;
	logic               fin_go;
	logic               res_found;
	logic [CNT_W-1:0]   res_idx;

	// input decode
	assign s_axis_tready = (state_q == S_IDLE);
	assign acc      = s_axis_tvalid && s_axis_tready;
	assign upd_acc  = acc && (s_axis_tuser == MODE_UPDATE);
	assign call_acc = acc && (s_axis_tuser == MODE_CALL);
	assign in_slot  = s_axis_tdata[SLOT_W-1:0];

	always_comb begin
		in_entry.floor  = s_axis_tdata[OFS_FLOOR +: FLOOR_W];
		in_entry.motion = motion_t'(s_axis_tdata[OFS_MOT +: 2]);
		in_entry.fault  = s_axis_tdata[OFS_FAULT];
		in_entry.stops  = s_axis_tdata[OFS_STOPS +: STOP_W];
	end

	// slots beyond the table are dropped
	assign ram_we = upd_acc && (32'(in_slot) < MAX_CARS);

	// scanned car count saturates at the table depth
	assign n_sat = (32'(cars_q) > MAX_CARS) ? CNT_W'(MAX_CARS) : cars_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q <= STRAT_NEAREST;
			cars_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_STRATEGY: strategy_q <= cfg_wdata[STRAT_W-1:0];
				REG_CARS:     cars_q     <= cfg_wdata;
				default:      cars_q     <= cars_q;
			endcase
		end
	end

	// car status table
	assign ram_re    = (state_q == S_SCAN);
	assign ram_raddr = IDX_W'(rd_cnt_q);

	ehd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_CARS),
		.AW    (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDX_W'(in_slot)),
		.wdata (in_entry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// key computation on the entry just read
	ehd_eval u_eval (
		.entry      (car_entry_t'(ram_rdata)),
		.call_floor (call_floor_q),
		.call_dir   (call_dir_q),
		.strategy   (strategy_q),
		.verdict    (verdict)
	);

	// result pick: nearest falls back to any healthy car
	always_comb begin
		if (strategy_q == STRAT_NEAREST && !pref_found_q) begin
			res_found = alt_found_q;
			res_idx   = alt_idx_q;
		end else begin
			res_found = pref_found_q;
			res_idx   = pref_idx_q;
		end
	end

	assign fin_go = (state_q == S_FINISH) && (!out_vld_q || m_axis_tready);

	// scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_cnt_q    <= '0;
			eval_vld_s1 <= 1'b0;
		end else begin
			eval_vld_s1 <= (state_q == S_SCAN);
			unique case (state_q)
				S_IDLE: begin
					rd_cnt_q <= '0;
					if (call_acc) begin
						state_q <= (n_sat == '0) ? S_FINISH : S_SCAN;
					end
				end
				S_SCAN: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == n_q - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// call context and read index pipeline
	always_ff @(posedge clk) begin
		eval_idx_s1 <= rd_cnt_q;
		if (call_acc) begin
			call_floor_q <= s_axis_tdata[OFS_CALL +: FLOOR_W];
			call_dir_q   <= s_axis_tdata[OFS_DIR];
			n_q          <= n_sat;
		end
	end

	// running best, strict compare keeps the lowest index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_found_q <= 1'b0;
			alt_found_q  <= 1'b0;
		end else if (call_acc) begin
			pref_found_q <= 1'b0;
			alt_found_q  <= 1'b0;
		end else if (eval_vld_s1) begin
			if (verdict.pref_ok && (!pref_found_q || verdict.pref_key < pref_key_q)) begin
				pref_found_q <= 1'b1;
			end
			if (verdict.alt_ok && (!alt_found_q || verdict.alt_key < alt_key_q)) begin
				alt_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_vld_s1) begin
			if (verdict.pref_ok && (!pref_found_q || verdict.pref_key < pref_key_q)) begin
				pref_key_q <= verdict.pref_key;
				pref_idx_q <= eval_idx_s1;
			end
			if (verdict.alt_ok && (!alt_found_q || verdict.alt_key < alt_key_q)) begin
				alt_key_q <= verdict.alt_key;
				alt_idx_q <= eval_idx_s1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fin_go) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_found_q <= res_found;
			out_idx_q   <= res_found ? CAR_W'(res_idx) : '0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = {{(8 - CAR_W){1'b0}}, out_idx_q};

`ifndef NO_ASSERTIONS
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("not-found beat carries a nonzero car index");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !ram_we)
		else $error("car table written during a scan");

	a_eval_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		eval_vld_s1 |-> eval_idx_s1 < n_q)
		else $error("evaluated slot beyond scanned car count");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go && res_found |-> res_idx < n_q)
		else $error("chosen car outside scanned range");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> m_axis_tvalid)
		else $error("finished call did not load the output register");
`endif

endmodule

@@ rtl/ehd_ram.sv @@
// generic single-write, single-read ram with registered read data
module ehd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/ehd_eval.sv @@
// per-car eligibility and sort keys for the three dispatch rules
module ehd_eval import ehd_pkg::*; (
	input  car_entry_t         entry,
	input  logic [FLOOR_W-1:0] call_floor,
	input  logic               call_dir,
	input  logic [STRAT_W-1:0] strategy,
	output eval_t              verdict
);

	logic [FLOOR_W-1:0] gap;
	logic               suits;
	logic               passing;
	logic [KEY_W-1:0]   base;
	logic [KEY_W-1:0]   stops5;
	logic [KEY_W-1:0]   score;

	// distance and direction match
	always_comb begin
		gap = (entry.floor > call_floor) ? (entry.floor - call_floor)
		                                 : (call_floor - entry.floor);
		suits = (entry.motion == MOT_IDLE) ||
		        (entry.motion == MOT_UP && call_dir == DIR_UP) ||
		        (entry.motion == MOT_DOWN && call_dir == DIR_DOWN);
		passing = (entry.motion == MOT_UP && call_dir == DIR_UP &&
		           entry.floor < call_floor) ||
		          (entry.motion == MOT_DOWN && call_dir == DIR_DOWN &&
		           entry.floor > call_floor);
	end

	// direction weighted score
	always_comb begin
		if (entry.motion == MOT_IDLE) begin
			base = KEY_W'(gap);
		end else if (passing) begin
			base = KEY_W'(gap >> 1);
		end else begin
			base = KEY_W'({gap, 1'b0});
		end
		stops5 = KEY_W'({entry.stops, 2'b00}) + KEY_W'(entry.stops);
		score  = base + stops5;
	end

	// rule select; unused rule code never qualifies
	always_comb begin
		verdict.alt_ok  = !entry.fault;
		verdict.alt_key = gap;
		unique case (strategy)
			STRAT_NEAREST: begin
				verdict.pref_ok  = !entry.fault && suits;
				verdict.pref_key = KEY_W'(gap);
			end
			STRAT_LEAST: begin
				verdict.pref_ok  = !entry.fault;
				verdict.pref_key = KEY_W'(entry.stops);
			end
			STRAT_SCORE: begin
				verdict.pref_ok  = !entry.fault;
				verdict.pref_key = score;
			end
			default: begin
				verdict.pref_ok  = 1'b0;
				verdict.pref_key = '0;
			end
		endcase
	end

endmodule
